// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

    localparam int PLE_DEPTH  = 16;
    localparam int PLE_DATA_W = 32;
    localparam int PLE_SLOT_W = 8;   // covers the largest supported depth
    localparam int PLE_CNT_W  = 9;   // covers counts up to the largest depth

    localparam logic [2:0] PLE_ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] PLE_ACT_INS_REAR  = 3'd1;
    localparam logic [2:0] PLE_ACT_INS_POS   = 3'd2;
    localparam logic [2:0] PLE_ACT_DEL_FIRST = 3'd3;
    localparam logic [2:0] PLE_ACT_DEL_LAST  = 3'd4;
    localparam logic [2:0] PLE_ACT_DEL_POS   = 3'd5;
    localparam logic [2:0] PLE_ACT_SEARCH    = 3'd6;
    localparam logic [2:0] PLE_ACT_CLEAR     = 3'd7;

    localparam logic [1:0] PLE_ST_OK     = 2'd0;
    localparam logic [1:0] PLE_ST_FULL   = 2'd1;
    localparam logic [1:0] PLE_ST_EMPTY  = 2'd2;
    localparam logic [1:0] PLE_ST_BADPOS = 2'd3;

    localparam logic [1:0] PLE_OP_HOLD   = 2'd0;
    localparam logic [1:0] PLE_OP_INS    = 2'd1;
    localparam logic [1:0] PLE_OP_DEL    = 2'd2;
    localparam logic [1:0] PLE_OP_SEARCH = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [PLE_SLOT_W-1:0] slot;
        logic [PLE_CNT_W-1:0]  cnt;
    } t_cell_ctl;

endpackage

// ===== rtl/ple_cell.sv =====
`timescale 1ns / 1ps

module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ple_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [ple_pkg::PLE_DATA_W-1:0] i_value,
    input  logic [ple_pkg::PLE_DATA_W-1:0]      i_left,
    input  logic [ple_pkg::PLE_DATA_W-1:0]      i_right,
    output logic [ple_pkg::PLE_DATA_W-1:0]      o_data,
    output logic                                o_match
);

    localparam logic [ple_pkg::PLE_SLOT_W-1:0] MY_SLOT = ple_pkg::PLE_SLOT_W'(IDX);
    localparam logic [ple_pkg::PLE_CNT_W-1:0]  MY_CNT  = ple_pkg::PLE_CNT_W'(IDX);

    logic [ple_pkg::PLE_DATA_W-1:0] r_data;
    logic [ple_pkg::PLE_DATA_W-1:0] n_data;
    logic                           r_match;
    logic                           n_match;

    always_comb begin
        n_data  = r_data;
        n_match = 1'b0;
        unique case (i_ctl.op)
            ple_pkg::PLE_OP_INS: begin
                // shift back behind the slot, take the new value at the slot
                if (MY_SLOT > i_ctl.slot) begin
                    n_data = i_left;
                end else if (MY_SLOT == i_ctl.slot) begin
                    n_data = $unsigned(i_value);
                end
            end
            ple_pkg::PLE_OP_DEL: begin
                if (MY_SLOT >= i_ctl.slot) begin
                    n_data = i_right;
                end
            end
            ple_pkg::PLE_OP_SEARCH: begin
                n_match = (r_data == $unsigned(i_value)) && (MY_CNT < i_ctl.cnt);
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ===== rtl/positional_list_engine_core.sv =====
`timescale 1ns / 1ps

// Bounded ordered list of up to DEPTH signed 32-bit values.
// Command channel: drive i_action, i_value and i_position with start high;
// the transaction is taken at the rising edge where start is high and busy
// is low. busy is high only while reset is applied and in the first cycle
// after it.
// Result channel: o_done pulses for one cycle, in the cycle after the
// command edge, with o_status, o_found and o_count (entry count after the
// command). The receiver cannot stall; it samples the result while o_done
// is high.
// Throughput is one command per cycle: every list cell shifts or compares
// in the same edge that takes the command, and the cells' match flags are
// OR-reduced in the result cycle, which overlaps the next command.
// Reset (i_rst_n low, synchronous) empties the list; cell contents are not
// cleared, since only entries below the count are ever read.

module positional_list_engine_core #(
    parameter int DEPTH = ple_pkg::PLE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_action,
    input  logic signed [ple_pkg::PLE_DATA_W-1:0] i_value,
    input  logic [CNT_W-1:0]                     i_position,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic                                 o_found,
    output logic [CNT_W-1:0]                     o_count
);

    localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(DEPTH);

    logic                          r_rdy;
    logic                          r_done;
    logic [1:0]                    r_status;
    logic [1:0]                    n_status;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          w_accept;
    logic [CNT_W:0]                w_cnt_x;
    logic [CNT_W:0]                w_pos_x;
    logic [CNT_W:0]                w_slot_x;
    logic                          w_full;
    logic                          w_empty;
    ple_pkg::t_cell_ctl            w_ctl;
    logic [ple_pkg::PLE_DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]              w_match;

    assign busy     = !r_rdy;
    assign w_accept = start && r_rdy;
    assign w_cnt_x  = {1'b0, r_count};
    assign w_pos_x  = {1'b0, i_position};
    assign w_full   = (w_cnt_x == DEPTH_X);
    assign w_empty  = (r_count == '0);

    // Decode the command into a status, the next count and one broadcast
    // control word that every cell sees in the same cycle.
    always_comb begin
        n_status = ple_pkg::PLE_ST_OK;
        n_count  = r_count;
        w_slot_x = '0;
        w_ctl.op = ple_pkg::PLE_OP_HOLD;
        unique case (i_action)
            ple_pkg::PLE_ACT_INS_FRONT: begin
                if (w_full) begin
                    n_status = ple_pkg::PLE_ST_FULL;
                end else begin
                    w_ctl.op = ple_pkg::PLE_OP_INS;
                end
            end
            ple_pkg::PLE_ACT_INS_REAR: begin
                w_slot_x = w_cnt_x;
                if (w_full) begin
                    n_status = ple_pkg::PLE_ST_FULL;
                end else begin
                    w_ctl.op = ple_pkg::PLE_OP_INS;
                end
            end
            ple_pkg::PLE_ACT_INS_POS: begin
                w_slot_x = w_pos_x - 1'b1;
                // fullness outranks a bad position
                if (w_full) begin
                    n_status = ple_pkg::PLE_ST_FULL;
                end else if (i_position == '0 || w_pos_x > w_cnt_x + 1'b1) begin
                    n_status = ple_pkg::PLE_ST_BADPOS;
                end else begin
                    w_ctl.op = ple_pkg::PLE_OP_INS;
                end
            end
            ple_pkg::PLE_ACT_DEL_FIRST: begin
                if (w_empty) begin
                    n_status = ple_pkg::PLE_ST_EMPTY;
                end else begin
                    w_ctl.op = ple_pkg::PLE_OP_DEL;
                end
            end
            ple_pkg::PLE_ACT_DEL_LAST: begin
                w_slot_x = w_cnt_x - 1'b1;
                if (w_empty) begin
                    n_status = ple_pkg::PLE_ST_EMPTY;
                end else begin
                    w_ctl.op = ple_pkg::PLE_OP_DEL;
                end
            end
            ple_pkg::PLE_ACT_DEL_POS: begin
                w_slot_x = w_pos_x - 1'b1;
                // emptiness outranks a bad position
                if (w_empty) begin
                    n_status = ple_pkg::PLE_ST_EMPTY;
                end else if (i_position == '0 || w_pos_x > w_cnt_x) begin
                    n_status = ple_pkg::PLE_ST_BADPOS;
                end else begin
                    w_ctl.op = ple_pkg::PLE_OP_DEL;
                end
            end
            ple_pkg::PLE_ACT_SEARCH: begin
                w_ctl.op = ple_pkg::PLE_OP_SEARCH;
            end
            ple_pkg::PLE_ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_status = ple_pkg::PLE_ST_OK;
            end
        endcase
        if (w_ctl.op == ple_pkg::PLE_OP_INS) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.op == ple_pkg::PLE_OP_DEL) begin
            n_count = r_count - 1'b1;
        end
        // drop the cell operation and the count change when no transaction is taken
        if (!w_accept) begin
            w_ctl.op = ple_pkg::PLE_OP_HOLD;
            n_count  = r_count;
        end
        w_ctl.slot = ple_pkg::PLE_SLOT_W'(w_slot_x);
        w_ctl.cnt  = ple_pkg::PLE_CNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (!i_rst_n) begin
            r_rdy   <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_rdy   <= 1'b1;
            r_done  <= w_accept;
            r_count <= n_count;
        end
    end

    // Row of cells: cell k holds list entry k and trades data with its
    // neighbors on insert (shift toward the rear) and delete (shift forward).
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [ple_pkg::PLE_DATA_W-1:0] w_left;
        logic [ple_pkg::PLE_DATA_W-1:0] w_right;

        if (k == 0) begin : g_head
            assign w_left = $unsigned(i_value);
        end else begin : g_body
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign w_right = $unsigned(i_value);
        end else begin : g_next
            assign w_right = w_data[k+1];
        end

        ple_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_match (w_match[k])
        );
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_found  = |w_match;
    assign o_count  = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= DEPTH_X)
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted transaction gave no result");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ple_pkg::PLE_ST_FULL) |-> ({1'b0, o_count} == DEPTH_X))
        else $error("full status with list not full");

    a_found_only_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> (o_done && o_status == ple_pkg::PLE_ST_OK))
        else $error("found flag outside a search result");
`endif

endmodule

// ===== tb/list_result_checker.sv =====
`timescale 1ns / 1ps

module list_result_checker #(
    parameter int DEPTH = ple_pkg::PLE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [2:0]              i_action,
    input  logic signed [31:0]      i_value,
    input  logic [CNT_W-1:0]        i_position,
    input  logic                    i_done,
    input  logic [1:0]              i_status,
    input  logic                    i_found,
    input  logic [CNT_W-1:0]        i_count,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);
    import ple_pkg::*;

    typedef struct {
        logic [1:0]       status;
        logic             found;
        logic [CNT_W-1:0] count;
    } list_result_t;

    // Shadow copy of the list contents and length.
    logic signed [31:0] list_vals[DEPTH];
    int unsigned        list_len;
    list_result_t       pending_results[$];
    int                 mismatches;
    int                 checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        mismatches   = 0;
        checked      = 0;
        list_len     = 0;
    end

    function automatic logic [1:0] insert_at(int unsigned slot, logic signed [31:0] val);
        if (list_len >= DEPTH)
            return PLE_ST_FULL;
        if (slot > list_len)
            return PLE_ST_BADPOS;
        for (int unsigned i = list_len; i > slot; i--)
            list_vals[i] = list_vals[i - 1];
        list_vals[slot] = val;
        list_len++;
        return PLE_ST_OK;
    endfunction

    function automatic logic [1:0] remove_at(int unsigned slot);
        if (list_len == 0)
            return PLE_ST_EMPTY;
        if (slot >= list_len)
            return PLE_ST_BADPOS;
        for (int unsigned i = slot; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i + 1];
        list_len--;
        return PLE_ST_OK;
    endfunction

    // Apply one command to the shadow list and return the result it must produce.
    function automatic list_result_t apply_list_command(logic [2:0] act,
                                                       logic signed [31:0] val,
                                                       logic [CNT_W-1:0] pos);
        list_result_t res;
        res.status = PLE_ST_OK;
        res.found  = 1'b0;
        case (act)
            PLE_ACT_INS_FRONT: res.status = insert_at(0, val);
            PLE_ACT_INS_REAR:  res.status = insert_at(list_len, val);
            PLE_ACT_INS_POS: begin
                // full wins over a bad position
                if (list_len >= DEPTH)
                    res.status = PLE_ST_FULL;
                else if (pos == 0)
                    res.status = PLE_ST_BADPOS;
                else
                    res.status = insert_at(pos - 1, val);
            end
            PLE_ACT_DEL_FIRST: res.status = remove_at(0);
            PLE_ACT_DEL_LAST: begin
                if (list_len == 0)
                    res.status = PLE_ST_EMPTY;
                else
                    res.status = remove_at(list_len - 1);
            end
            PLE_ACT_DEL_POS: begin
                if (list_len == 0)
                    res.status = PLE_ST_EMPTY;
                else if (pos == 0)
                    res.status = PLE_ST_BADPOS;
                else
                    res.status = remove_at(pos - 1);
            end
            PLE_ACT_SEARCH: begin
                for (int unsigned i = 0; i < list_len; i++)
                    if (list_vals[i] == val)
                        res.found = 1'b1;
            end
            default: list_len = 0;
        endcase
        res.count = list_len[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        list_result_t want;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with nothing outstanding: status=%0d found=%0d count=%0d",
                                 $time, i_status, i_found, i_count);
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (want.status !== i_status || want.found !== i_found ||
                        want.count !== i_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: status %0d/%0d found %0d/%0d count %0d/%0d (exp/act)",
                                     $time, want.status, i_status, want.found, i_found,
                                     want.count, i_count);
                    end
                end
            end
            if (i_start && !i_busy)
                pending_results.push_back(apply_list_command(i_action, i_value, i_position));
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ple_pkg::*;

    localparam int DEPTH = PLE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum int {BURST_GROW, BURST_SHRINK, BURST_MIXED} burst_mode_e;

    // Every input starts at a known value.
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    start      = 1'b0;
    logic [2:0]              i_action   = '0;
    logic signed [31:0]      i_value    = '0;
    logic [CNT_W-1:0]        i_position = '0;
    logic                    busy;
    logic                    o_done;
    logic [1:0]              o_status;
    logic                    o_found;
    logic [CNT_W-1:0]        o_count;

    int                      fail_count;
    int                      outstanding;
    int                      results_checked;
    int                      commands_sent = 0;
    logic signed [31:0]      value_pool[8];

    always #1 i_clk = ~i_clk;

    positional_list_engine_core #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_action   (i_action),
        .i_value    (i_value),
        .i_position (i_position),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_count    (o_count)
    );

    list_result_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_done       (o_done),
        .i_status     (o_status),
        .i_found      (o_found),
        .i_count      (o_count),
        .o_fail_count (fail_count),
        .o_pending    (outstanding),
        .o_checked    (results_checked)
    );

    // Present one command and hold it until the edge that takes the transaction.
    // start stays high on return so that a back-to-back command needs no
    // second assignment in the same step.
    task automatic send_command(input logic [2:0] act, input logic signed [31:0] val,
                                input logic [CNT_W-1:0] pos);
        start      <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        commands_sent++;
    endtask

    // Drop start and hold off until every predicted result has been checked.
    // The first edge lets the checker's count catch up with the last transaction.
    task automatic drain_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // Weight the action mix so the list fills up, empties out, or wanders.
    function automatic logic [2:0] pick_action(burst_mode_e mode);
        int roll;
        int ins_pct;
        int del_pct;
        roll    = $urandom_range(0, 99);
        ins_pct = (mode == BURST_GROW) ? 70 : (mode == BURST_SHRINK) ? 15 : 40;
        del_pct = (mode == BURST_GROW) ? 15 : (mode == BURST_SHRINK) ? 70 : 40;
        if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
                0:       return PLE_ACT_INS_FRONT;
                1:       return PLE_ACT_INS_REAR;
                default: return PLE_ACT_INS_POS;
            endcase
        end else if (roll < ins_pct + del_pct) begin
            case ($urandom_range(0, 2))
                0:       return PLE_ACT_DEL_FIRST;
                1:       return PLE_ACT_DEL_LAST;
                default: return PLE_ACT_DEL_POS;
            endcase
        end else if (roll < 98) begin
            return PLE_ACT_SEARCH;
        end
        return PLE_ACT_CLEAR;
    endfunction

    // Mostly reuse a small pool so searches hit; sometimes a fresh random word.
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Mostly positions that can be legal; the rest spans the whole field, zero included.
    function automatic logic [CNT_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85)
            return CNT_W'($urandom_range(1, DEPTH + 1));
        return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
    endfunction

    initial begin
        int idle_pct_of_phase[4];
        int items_left;
        int burst_len;
        burst_mode_e mode;

        idle_pct_of_phase = '{0, 84, 0, 34};
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // Hold reset, then release it for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-list deletes, bad positions, extremes, order checks.
        send_command(PLE_ACT_DEL_FIRST, 0, 1);
        send_command(PLE_ACT_DEL_LAST, 0, 1);
        send_command(PLE_ACT_DEL_POS, 0, 0);          // empty is reported before position
        send_command(PLE_ACT_SEARCH, 0, 1);           // search on empty list misses
        send_command(PLE_ACT_INS_POS, 5, 0);          // position zero on insert
        send_command(PLE_ACT_INS_POS, 5, 2);          // beyond count+1
        send_command(PLE_ACT_INS_REAR, 32'sh7FFF_FFFF, 1); // rear insert on empty list
        send_command(PLE_ACT_INS_REAR, 32'sh8000_0000, 1); // rear insert on one entry
        send_command(PLE_ACT_INS_FRONT, -32'sd1, 1);
        send_command(PLE_ACT_INS_POS, 0, 4);          // exactly count+1
        send_command(PLE_ACT_INS_POS, 9, 31);
        send_command(PLE_ACT_SEARCH, 32'sh8000_0000, 1);
        send_command(PLE_ACT_SEARCH, 32'sh0001_2345, 1);
        send_command(PLE_ACT_DEL_POS, 0, 0);          // position zero on delete
        send_command(PLE_ACT_DEL_POS, 0, 5);          // beyond count
        send_command(PLE_ACT_DEL_POS, 0, 2);
        send_command(PLE_ACT_DEL_LAST, 0, 1);
        send_command(PLE_ACT_DEL_FIRST, 0, 1);
        send_command(PLE_ACT_CLEAR, 0, 1);
        send_command(PLE_ACT_INS_POS, 32'sh5A5A_A5A5, 1); // position 1 on empty list
        send_command(PLE_ACT_DEL_POS, 0, 1);
        send_command(PLE_ACT_CLEAR, 0, 1);            // clear on empty list
        drain_results();

        // Random part: bursts weighted to grow the list, shrink it, or mix, over
        // four phases whose sender idle odds are 0, 84, 0 and 34 percent. Each cycle
        // idles on its own draw, so gaps of any length show up.
        for (int phase = 0; phase < 4; phase++) begin
            items_left = 138;
            while (items_left > 0) begin
                mode      = burst_mode_e'($urandom_range(0, 2));
                burst_len = $urandom_range(10, 40);
                for (int n = 0; n < burst_len && items_left > 0; n++) begin
                    send_command(pick_action(mode), pick_value(), pick_position());
                    items_left--;
                    while ($urandom_range(0, 99) < idle_pct_of_phase[phase]) begin
                        start <= 1'b0;
                        @(posedge i_clk);
                    end
                end
            end
            // Pause until every result of this phase is back.
            drain_results();
        end

        // Let any stray strobe show up before the verdict.
        repeat (4) @(posedge i_clk);

        $display("Drove %0d list commands covering all eight actions, full and empty lists,",
                 commands_sent);
        $display("positions 0..31 and four sender idling profiles; %0d results compared.",
                 results_checked);
        if (outstanding != 0)
            $display("%0d predicted results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_core.sv
tb/list_result_checker.sv
tb/testbench.sv
